// ===== sv/rvs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the rotated voxel store: beat payload types, register map
// and fixed widths. No dependencies.
package rvs_pkg;

    // Register indices, decoded from paddr[3:2] (byte offsets 0x0, 0x4, 0x8)
    localparam logic [1:0] REG_DIM_X = 2'd0;
    localparam logic [1:0] REG_DIM_Y = 2'd1;
    localparam logic [1:0] REG_DIM_Z = 2'd2;

    localparam int PADDR_W = 4;
    localparam int DIM_W   = 6;
    localparam int COLOR_W = 32;
    localparam int OCC_W   = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

    // Orientation codes
    localparam logic [1:0] TURN_0   = 2'd0;
    localparam logic [1:0] TURN_90  = 2'd1;
    localparam logic [1:0] TURN_180 = 2'd2;
    localparam logic [1:0] TURN_270 = 2'd3;

    // Access modes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Headroom for index math before truncation to the memory address
    localparam int ROW_CALC_W = 17;
    localparam int LIN_CALC_W = 23;

    typedef struct packed {
        logic               mode;
        logic [4:0]         rel_x;
        logic [4:0]         rel_y;
        logic [4:0]         rel_z;
        logic [1:0]         quarter_turns;
        logic [COLOR_W-1:0] write_color;
    } req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic               coords_valid;
        logic               occupied;
    } rsp_t;

    typedef struct packed {
        logic [DIM_W-1:0] dim_x;
        logic [DIM_W-1:0] dim_y;
        logic [DIM_W-1:0] dim_z;
    } dims_t;

    // Status of the mapped access, index unit to top
    typedef struct packed {
        logic       valid;
        logic [4:0] lx;
    } loc_t;

endpackage

// ===== sv/rvs_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/rvs_cfg.sv =====
`timescale 1ns / 1ps
// APB-style register block holding the three voxel dimensions.
// Depends on rvs_pkg.
module rvs_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rvs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rvs_pkg::dims_t               dims
);

    rvs_pkg::dims_t dims_reg;
    rvs_pkg::dims_t dims_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign dims   = dims_reg;

    always_comb
    begin
        dims_next = dims_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                rvs_pkg::REG_DIM_X: dims_next.dim_x = pwdata[rvs_pkg::DIM_W-1:0];
                rvs_pkg::REG_DIM_Y: dims_next.dim_y = pwdata[rvs_pkg::DIM_W-1:0];
                rvs_pkg::REG_DIM_Z: dims_next.dim_z = pwdata[rvs_pkg::DIM_W-1:0];
                default:            dims_next = dims_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.dim_x <= rvs_pkg::DIM_RESET;
            dims_reg.dim_y <= rvs_pkg::DIM_RESET;
            dims_reg.dim_z <= rvs_pkg::DIM_RESET;
        end
        else
        begin
            dims_reg <= dims_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rvs_pkg::REG_DIM_X: prdata = {26'd0, dims_reg.dim_x};
            rvs_pkg::REG_DIM_Y: prdata = {26'd0, dims_reg.dim_y};
            rvs_pkg::REG_DIM_Z: prdata = {26'd0, dims_reg.dim_z};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/rvs_addr.sv =====
`timescale 1ns / 1ps
// Index unit: rotation to local coordinates, bounds check, row and linear
// index over three register stages. Depends on rvs_pkg.
module rvs_addr #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32,
    parameter int ROW_W = 10,
    parameter int LIN_W = 15
) (
    input  logic             clk,
    input  rvs_pkg::req_t    req,
    input  rvs_pkg::dims_t   dims,
    output logic [ROW_W-1:0] row,
    output logic [LIN_W-1:0] lin,
    output rvs_pkg::loc_t    loc
);

    logic [rvs_pkg::DIM_W-1:0] dx;
    logic [rvs_pkg::DIM_W-1:0] dy;
    logic [rvs_pkg::DIM_W-1:0] dz;
    logic signed [7:0]         dx_s;
    logic signed [7:0]         dz_s;
    logic signed [7:0]         rx_s;
    logic signed [7:0]         rz_s;
    logic signed [7:0]         lx_s;
    logic signed [7:0]         lz_s;
    logic                      in_bounds;

    // stage 1: mapped coordinates
    logic       s1_valid_reg;
    logic [4:0] s1_lx_reg;
    logic [4:0] s1_ly_reg;
    logic [5:0] s1_lz_reg;
    // stage 2: row index
    logic             s2_valid_reg;
    logic [4:0]       s2_lx_reg;
    logic [ROW_W-1:0] s2_row_reg;
    // stage 3: linear index
    logic             s3_valid_reg;
    logic [4:0]       s3_lx_reg;
    logic [ROW_W-1:0] s3_row_reg;
    logic [LIN_W-1:0] s3_lin_reg;

    logic [rvs_pkg::ROW_CALC_W-1:0] row_full;
    logic [rvs_pkg::LIN_CALC_W-1:0] lin_full;

    // dimensions saturate at the build-time maximum
    assign dx = (int'(dims.dim_x) > MAX_X) ? rvs_pkg::DIM_W'(MAX_X) : dims.dim_x;
    assign dy = (int'(dims.dim_y) > MAX_Y) ? rvs_pkg::DIM_W'(MAX_Y) : dims.dim_y;
    assign dz = (int'(dims.dim_z) > MAX_Z) ? rvs_pkg::DIM_W'(MAX_Z) : dims.dim_z;

    assign dx_s = signed'({2'b00, dx});
    assign dz_s = signed'({2'b00, dz});
    assign rx_s = signed'({3'b000, req.rel_x});
    assign rz_s = signed'({3'b000, req.rel_z});

    always_comb
    begin
        case (req.quarter_turns)
            rvs_pkg::TURN_90:
            begin
                lx_s = rz_s;
                lz_s = dz_s - rx_s - 8'sd1;
            end
            rvs_pkg::TURN_180:
            begin
                lx_s = dx_s - rx_s - 8'sd1;
                lz_s = dz_s - rz_s - 8'sd1;
            end
            rvs_pkg::TURN_270:
            begin
                lx_s = dx_s - rz_s - 8'sd1;
                lz_s = rx_s;
            end
            default:
            begin
                lx_s = rx_s;
                lz_s = rz_s;
            end
        endcase
    end

    assign in_bounds = !lx_s[7] && (lx_s < dx_s)
                    && ({1'b0, req.rel_y} < dy)
                    && !lz_s[7] && (lz_s < dz_s);

    // row = ly*dz + lz, lin = row*dx + lx
    assign row_full = rvs_pkg::ROW_CALC_W'(s1_ly_reg) * rvs_pkg::ROW_CALC_W'(dz)
                    + rvs_pkg::ROW_CALC_W'(s1_lz_reg);
    assign lin_full = rvs_pkg::LIN_CALC_W'(s2_row_reg) * rvs_pkg::LIN_CALC_W'(dx)
                    + rvs_pkg::LIN_CALC_W'(s2_lx_reg);

    always_ff @(posedge clk)
    begin
        s1_valid_reg <= in_bounds;
        s1_lx_reg    <= lx_s[4:0];
        s1_ly_reg    <= req.rel_y;
        s1_lz_reg    <= lz_s[5:0];

        s2_valid_reg <= s1_valid_reg;
        s2_lx_reg    <= s1_lx_reg;
        s2_row_reg   <= row_full[ROW_W-1:0];

        s3_valid_reg <= s2_valid_reg;
        s3_lx_reg    <= s2_lx_reg;
        s3_row_reg   <= s2_row_reg;
        s3_lin_reg   <= lin_full[LIN_W-1:0];
    end

    assign row       = s3_row_reg;
    assign lin       = s3_lin_reg;
    assign loc.valid = s3_valid_reg;
    assign loc.lx    = s3_lx_reg;

endmodule

// ===== sv/rotated_voxel_store_with_occupancy_top.sv =====
`timescale 1ns / 1ps
// Top level of the rotated voxel store: command handshake, sequencer,
// colour and occupancy memories. Depends on rvs_pkg, rvs_cfg, rvs_addr, rvs_ram.
//
//  channel   handshake                         payload        beat taken when
//  -------   ---------------------------------  -------------  -----------------------------
//  command   start / busy                       cmd (req_t)    start && !busy at clk rise
//  result    done (one-cycle strobe)            rsp (rsp_t)    every cycle done is high
//  config    psel/penable/pwrite/pready (APB)   paddr, pwdata  psel && penable && pwrite
//
// Sequencing: one access at a time; a new command is accepted only once the
// previous one has left the sequencer. The result strobe follows accept through
// three index stages (map, row multiply, linear multiply), a memory read, a
// read-modify-write, then the registered result.
// Reset: both memories are cleared by a sweep over the MAX_X*MAX_Y*MAX_Z colour addresses
// (32768 at the default sizes), one colour word per cycle and, over the first MAX_Y*MAX_Z,
// one occupancy row too; busy is high during the sweep. Config writes are taken throughout.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module rotated_voxel_store_with_occupancy_top #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  rvs_pkg::req_t                cmd,
    output logic                         busy,
    output logic                         done,
    output rvs_pkg::rsp_t                rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rvs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int VOXEL_DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int ROW_DEPTH   = MAX_Y * MAX_Z;
    localparam int LIN_W       = (VOXEL_DEPTH > 1) ? $clog2(VOXEL_DEPTH) : 1;
    localparam int ROW_W       = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam logic [LIN_W-1:0] CLR_LAST = LIN_W'(VOXEL_DEPTH - 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_MAP   = 7'b0000100,
        ST_ROW   = 7'b0001000,
        ST_LIN   = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_WB    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [LIN_W-1:0] clr_reg;
    logic [LIN_W-1:0] clr_next;
    logic             done_reg;
    logic             done_next;
    rvs_pkg::req_t    req_reg;
    rvs_pkg::rsp_t    rsp_reg;
    rvs_pkg::rsp_t    rsp_next;

    rvs_pkg::dims_t   dims;
    logic [ROW_W-1:0] row;
    logic [LIN_W-1:0] lin;
    rvs_pkg::loc_t    loc;

    logic                        accept;
    logic                        clearing;
    logic                        clr_in_rows;
    logic                        wb_write;
    logic                        alpha_set;
    logic [rvs_pkg::OCC_W-1:0]   occ_mask;
    logic [rvs_pkg::OCC_W-1:0]   occ_new;
    logic [4:0]                  occ_bit;

    logic                        col_we;
    logic [LIN_W-1:0]            col_waddr;
    logic [rvs_pkg::COLOR_W-1:0] col_wdata;
    logic [rvs_pkg::COLOR_W-1:0] col_rdata;
    logic                        occ_we;
    logic [ROW_W-1:0]            occ_waddr;
    logic [rvs_pkg::OCC_W-1:0]   occ_wdata;
    logic [rvs_pkg::OCC_W-1:0]   occ_rdata;
    logic                        rd_en;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign done     = done_reg;
    assign rsp      = rsp_reg;
    assign clearing = (state_reg == ST_CLEAR);
    assign rd_en    = (state_reg == ST_READ);

    rvs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    // The index stages run freely off the held command; the sequencer
    // samples them once the pipeline has filled.
    rvs_addr #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z),
        .ROW_W (ROW_W),
        .LIN_W (LIN_W)
    ) u_addr (
        .clk  (clk),
        .req  (req_reg),
        .dims (dims),
        .row  (row),
        .lin  (lin),
        .loc  (loc)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + LIN_W'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:  state_next = ST_ROW;
            ST_ROW:  state_next = ST_LIN;
            ST_LIN:  state_next = ST_READ;
            ST_READ: state_next = ST_WB;
            ST_WB:   state_next = ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
    end

    // Read-modify-write. Only one access is in flight, so a read never
    // races a write to the same entry.
    assign clr_in_rows = (32'(clr_reg) < 32'(ROW_DEPTH));
    assign wb_write    = (state_reg == ST_WB) && loc.valid
                      && (req_reg.mode == rvs_pkg::MODE_WRITE);
    assign alpha_set   = (req_reg.write_color[7:0] != 8'd0);
    assign occ_mask    = 32'h8000_0000 >> loc.lx;
    assign occ_new     = alpha_set ? (occ_rdata | occ_mask) : (occ_rdata & ~occ_mask);
    assign occ_bit     = 5'd31 - loc.lx;

    assign col_we    = clearing || wb_write;
    assign col_waddr = clearing ? clr_reg : lin;
    assign col_wdata = clearing ? '0 : req_reg.write_color;
    assign occ_we    = (clearing && clr_in_rows) || wb_write;
    assign occ_waddr = clearing ? clr_reg[ROW_W-1:0] : row;
    assign occ_wdata = clearing ? '0 : occ_new;

    always_comb
    begin
        done_next = (state_reg == ST_WB);
        rsp_next  = rsp_reg;
        if (state_reg == ST_WB)
        begin
            if (!loc.valid)
            begin
                rsp_next.read_color   = '0;
                rsp_next.coords_valid = 1'b0;
                rsp_next.occupied     = 1'b0;
            end
            else if (req_reg.mode == rvs_pkg::MODE_WRITE)
            begin
                rsp_next.read_color   = req_reg.write_color;
                rsp_next.coords_valid = 1'b1;
                rsp_next.occupied     = alpha_set;
            end
            else
            begin
                rsp_next.read_color   = col_rdata;
                rsp_next.coords_valid = 1'b1;
                rsp_next.occupied     = occ_rdata[occ_bit];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= cmd;
        end
        rsp_reg <= rsp_next;
    end

    rvs_ram #(
        .WIDTH (rvs_pkg::COLOR_W),
        .DEPTH (VOXEL_DEPTH),
        .AW    (LIN_W)
    ) u_color_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .re    (rd_en),
        .raddr (lin),
        .rdata (col_rdata)
    );

    rvs_ram #(
        .WIDTH (rvs_pkg::OCC_W),
        .DEPTH (ROW_DEPTH),
        .AW    (ROW_W)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .re    (rd_en),
        .raddr (row),
        .rdata (occ_rdata)
    );

endmodule

// ===== sv/rvs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on command/result timing of the voxel store, bound to
// the top level. Depends on rvs_pkg and rotated_voxel_store_with_occupancy_top.
module rvs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input rvs_pkg::rsp_t rsp
);

    // an accepted command locks the port on the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy
    ) else $error("busy not raised after accepted command");

    // each accepted command yields its result beat after the map, row, linear, read and write-back states
    a_result_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done
    ) else $error("result beat missing six cycles after accept");

    // result beats only appear once the block has returned to idle
    a_done_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> !busy
    ) else $error("result beat while busy");

    // out-of-range accesses report all zero
    a_invalid_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !rsp.coords_valid) |-> (rsp.read_color == 32'd0 && !rsp.occupied)
    ) else $error("invalid access returned nonzero data");

endmodule

bind rotated_voxel_store_with_occupancy_top rvs_checker u_rvs_checker (.*);

// ===== verif/tb_rotated_voxel_store_with_occupancy_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rotated_voxel_store_with_occupancy_top: directed
// and random voxel accesses over APB-set dimensions, scored against a local model.
// Depends on rvs_pkg and the RTL of the top level.
module tb_rotated_voxel_store_with_occupancy_top;
    import rvs_pkg::*;

    localparam int MAX_X = 32;
    localparam int MAX_Y = 32;
    localparam int MAX_Z = 32;
    localparam int VOXEL_DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int ROW_DEPTH   = MAX_Y * MAX_Z;
    // Slack after the last result before reconfiguring
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_BEATS   = 70;

    logic         clk;
    logic         rst_n;
    logic         start;
    req_t         cmd;
    logic         busy;
    logic         done;
    rsp_t         rsp;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Local copy of the block state: colour words, occupancy rows, dimensions
    bit   [COLOR_W-1:0] voxel_color [VOXEL_DEPTH];
    bit   [OCC_W-1:0]   occ_rows    [ROW_DEPTH];
    logic [DIM_W-1:0]   dim_reg     [3];

    // Results predicted for accepted command beats, oldest first
    rsp_t expected_rsp_q[$];
    int   mismatch_count;

    rotated_voxel_store_with_occupancy_top #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the reset sweep plus a full run with long gaps.
    initial
    begin
        #3_000_000;
        $display("tb_rotated_voxel_store_with_occupancy_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Register values above the array size saturate to it
    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    // Maps the rotated coordinates to local ones, applies the access to the
    // local state and returns the result beat the block must produce.
    function automatic rsp_t apply_voxel_access(input req_t req);
        int   dx, dy, dz;
        int   rx, rz;
        int   lx, ly, lz;
        int   lin, row;
        rsp_t r;
        dx = eff_dim(dim_reg[REG_DIM_X], MAX_X);
        dy = eff_dim(dim_reg[REG_DIM_Y], MAX_Y);
        dz = eff_dim(dim_reg[REG_DIM_Z], MAX_Z);
        rx = int'(req.rel_x);
        rz = int'(req.rel_z);
        lx = rx;
        ly = int'(req.rel_y);
        lz = rz;
        case (req.quarter_turns)
            TURN_90:
            begin
                lx = rz;
                lz = dz - rx - 1;
            end
            TURN_180:
            begin
                lx = dx - rx - 1;
                lz = dz - rz - 1;
            end
            TURN_270:
            begin
                lx = dx - rz - 1;
                lz = rx;
            end
            default: ;
        endcase
        r = '0;
        // Outside the box (also every access with a zero dimension): no effect
        if (lx < 0 || lx >= dx || ly >= dy || lz < 0 || lz >= dz)
            return r;
        lin = ly * dx * dz + lz * dx + lx;
        row = ly * dz + lz;
        if (req.mode == MODE_WRITE)
        begin
            voxel_color[lin] = req.write_color;
            occ_rows[row][31 - lx] = (req.write_color[7:0] != 8'd0);
        end
        r.read_color   = voxel_color[lin];
        r.coords_valid = 1'b1;
        r.occupied     = occ_rows[row][31 - lx];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every done cycle is one result beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %h", $realtime, rsp);
                mismatch_count++;
            end
            else
            begin
                exp_rsp = expected_rsp_q.pop_front();
                if (rsp.read_color !== exp_rsp.read_color)
                begin
                    $display("%0t: read_color expected %h actual %h",
                             $realtime, exp_rsp.read_color, rsp.read_color);
                    mismatch_count++;
                end
                if (rsp.coords_valid !== exp_rsp.coords_valid)
                begin
                    $display("%0t: coords_valid expected %b actual %b",
                             $realtime, exp_rsp.coords_valid, rsp.coords_valid);
                    mismatch_count++;
                end
                if (rsp.occupied !== exp_rsp.occupied)
                begin
                    $display("%0t: occupied expected %b actual %b",
                             $realtime, exp_rsp.occupied, rsp.occupied);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones, and plenty of back-to-back beats
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(7, 1);
        else if (r < 95)
            return $urandom_range(20, 8);
        return $urandom_range(60, 30);
    endfunction

    // One command beat. start goes up on a falling edge, the beat is taken at
    // the first rising edge with busy low, and start drops on the next
    // falling edge so an idle block never sees a stale command.
    task automatic send_access(input req_t req, input int gap);
        repeat (gap) @(negedge clk);
        @(negedge clk);
        cmd   = req;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_rsp_q.push_back(apply_voxel_access(req));
        @(negedge clk);
        start = 1'b0;
    endtask

    // Hold the sender until every predicted result has come back
    task automatic drain_results();
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read-back; the upper data bits carry noise
    task automatic write_dim(input logic [1:0] reg_idx, input logic [DIM_W-1:0] value);
        logic [31:0] wdata;
        wdata      = $urandom;
        wdata[5:0] = value;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        dim_reg[reg_idx] = value;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {26'd0, value})
        begin
            $display("%0t: prdata of register %0d expected %h actual %h",
                     $realtime, reg_idx, {26'd0, value}, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y,
                            input logic [DIM_W-1:0] z);
        drain_results();
        write_dim(REG_DIM_X, x);
        write_dim(REG_DIM_Y, y);
        write_dim(REG_DIM_Z, z);
    endtask

    function automatic req_t make_access(input logic mode, input int x, input int y,
                                         input int z, input logic [1:0] turns,
                                         input logic [31:0] color);
        req_t req;
        req.mode          = mode;
        req.rel_x         = x[4:0];
        req.rel_y         = y[4:0];
        req.rel_z         = z[4:0];
        req.quarter_turns = turns;
        req.write_color   = color;
        return req;
    endfunction

    // Mostly accesses that land inside the rotated box, with the rest
    // spread over the whole coordinate range to hit the bounds checks.
    function automatic req_t random_access();
        req_t req;
        int   dx, dy, dz;
        req.mode          = 1'($urandom_range(1, 0));
        req.quarter_turns = 2'($urandom_range(3, 0));
        req.write_color   = $urandom;
        if ($urandom_range(3, 0) == 0)
            req.write_color[7:0] = 8'd0;
        dx = eff_dim(dim_reg[REG_DIM_X], MAX_X);
        dy = eff_dim(dim_reg[REG_DIM_Y], MAX_Y);
        dz = eff_dim(dim_reg[REG_DIM_Z], MAX_Z);
        if ($urandom_range(99, 0) < 80 && dx > 0 && dy > 0 && dz > 0)
        begin
            req.rel_y = 5'($urandom_range(dy - 1, 0));
            if (req.quarter_turns == TURN_90 || req.quarter_turns == TURN_270)
            begin
                req.rel_x = 5'($urandom_range(dz - 1, 0));
                req.rel_z = 5'($urandom_range(dx - 1, 0));
            end
            else
            begin
                req.rel_x = 5'($urandom_range(dx - 1, 0));
                req.rel_z = 5'($urandom_range(dz - 1, 0));
            end
        end
        else
        begin
            req.rel_x = 5'($urandom_range(31, 0));
            req.rel_y = 5'($urandom_range(31, 0));
            req.rel_z = 5'($urandom_range(31, 0));
        end
        return req;
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        int r;
        r = $urandom_range(99, 0);
        if (r < 3)
            return '0;
        else if (r < 70)
            return DIM_W'($urandom_range(6, 1));
        else if (r < 85)
            return DIM_W'($urandom_range(32, 7));
        return DIM_W'($urandom_range(63, 33));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset dimensions (32 cubed): far corners in all four orientations,
    // opaque and transparent writes, voxels reached from two frames.
    task automatic test_default_corners();
        send_access(make_access(MODE_WRITE, 0, 0, 0, TURN_0, 32'hFFFF_FFFF), 0);
        send_access(make_access(MODE_WRITE, 31, 31, 31, TURN_0, 32'h0000_0000), 0);
        send_access(make_access(MODE_WRITE, 0, 31, 31, TURN_90, 32'hA5A5_A501), 1);
        send_access(make_access(MODE_READ, 31, 31, 31, TURN_0, 32'h0000_0000), 0);
        send_access(make_access(MODE_WRITE, 31, 0, 0, TURN_270, 32'h5A5A_5AFF), 2);
        send_access(make_access(MODE_READ, 0, 0, 0, TURN_180, 32'hFFFF_FFFF), 0);
        send_access(make_access(MODE_READ, 31, 0, 31, TURN_180, 32'h0000_0000), 0);
        // Transparent colour over an opaque voxel clears its occupancy
        send_access(make_access(MODE_WRITE, 0, 0, 0, TURN_0, 32'h1234_5600), 0);
    endtask

    // Small box: each axis just past its edge, including the negative
    // local coordinates the 90 and 270 degree maps produce.
    task automatic test_out_of_range();
        set_dims(6'd5, 6'd4, 6'd3);
        send_access(make_access(MODE_WRITE, 4, 3, 2, TURN_0, 32'hDEAD_BEEF), 0);
        send_access(make_access(MODE_READ, 5, 0, 0, TURN_0, 32'h0000_0000), 0);
        send_access(make_access(MODE_WRITE, 0, 4, 0, TURN_0, 32'h1111_1111), 3);
        send_access(make_access(MODE_READ, 3, 0, 0, TURN_90, 32'h0000_0000), 0);
        send_access(make_access(MODE_READ, 0, 0, 5, TURN_270, 32'h0000_0000), 0);
        send_access(make_access(MODE_READ, 0, 3, 0, TURN_180, 32'h0000_0000), 0);
    endtask

    // Any zero dimension rejects every access
    task automatic test_zero_dims();
        set_dims(6'd0, 6'd4, 6'd3);
        send_access(make_access(MODE_WRITE, 0, 0, 0, TURN_0, 32'hCAFE_00FF), 0);
        set_dims(6'd5, 6'd0, 6'd3);
        send_access(make_access(MODE_READ, 4, 0, 2, TURN_0, 32'h0000_0000), 0);
    endtask

    // Register values above 32 behave as 32
    task automatic test_oversized_dims();
        set_dims(6'd63, 6'd33, 6'd40);
        send_access(make_access(MODE_READ, 31, 31, 31, TURN_0, 32'h0000_0000), 0);
        send_access(make_access(MODE_READ, 31, 0, 31, TURN_0, 32'h0000_0000), 0);
    endtask

    // New dimensions reinterpret what is already stored
    task automatic test_dim_change();
        set_dims(6'd3, 6'd4, 6'd5);
        send_access(make_access(MODE_READ, 2, 3, 4, TURN_0, 32'h0000_0000), 0);
        send_access(make_access(MODE_READ, 0, 0, 0, TURN_0, 32'h0000_0000), 0);
        send_access(make_access(MODE_WRITE, 1, 2, 3, TURN_90, 32'h0102_0300), 0);
    endtask

    // Random traffic over a series of dimension settings, mostly small boxes
    // so reads land on voxels written earlier in the same phase.
    task automatic test_random_phases();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_dims(6'd1, 6'd1, 6'd1);
                1: set_dims(6'd32, 6'd32, 6'd32);
                2: set_dims(6'd63, 6'd63, 6'd63);
                3: set_dims(random_dim(), 6'd0, random_dim());
                default: set_dims(random_dim(), random_dim(), random_dim());
            endcase
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // Occasionally, and once for certain, let everything drain
                if ((phase == 5 && n == PHASE_BEATS / 2) || $urandom_range(149, 0) == 0)
                    drain_results();
                send_access(random_access(), pick_gap());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        mismatch_count = 0;
        for (int i = 0; i < 3; i++)
            dim_reg[i] = DIM_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // The clearing sweep keeps busy high; the first beat waits it out
        test_default_corners();
        test_out_of_range();
        test_zero_dims();
        test_oversized_dims();
        test_dim_change();
        test_random_phases();
        drain_results();
        if (mismatch_count == 0)
            $display("tb_rotated_voxel_store_with_occupancy_top OK");
        else
            $display("tb_rotated_voxel_store_with_occupancy_top NOT OK");
        $finish;
    end

endmodule
